// ----- hw/rtl/scd_pkg.sv -----
package scd_pkg;

    localparam logic [1:0] MAGIC_BITS = 2'b11;

    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_RESET  = 2'd2;
    localparam logic [1:0] CMD_BOUNDS = 2'd3;

    localparam logic [9:0] MM_SCALE = 10'd1000;

    // exponent + product shift above this saturates; bias + mantissa bits
    localparam logic [8:0] SAT_LIMIT  = 9'd141;
    localparam logic [8:0] EXP_OFFSET = 9'd150;
    localparam logic [8:0] SHIFT_ZERO = 9'd25;

    typedef struct packed {
        logic        is_cmd;
        logic        start;
        logic        rst;
        logic        active;
        logic        clear;
        logic [15:0] wmin;
        logic [15:0] wmax;
        logic [31:0] count;
        logic        neg;
        logic        nan;
        logic [7:0]  ex;
        logic [33:0] prod;
    } mid_t;

endpackage

// ----- hw/rtl/setpoint_command_decoder_unit.sv -----
// Requests pass the input, decode/multiply and result registers in turn to m_*.
// Throughput: one request per cycle; input, decode/multiply and result registers
// form a three-stage pipeline that stalls only on m_ready.
// Reset (aresetn low, synchronous): bounds, cache, command count and constraint
// word clear to zero, constraints off, pipeline empty.
module setpoint_command_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_x_word,
    input  logic [31:0] s_y_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_command,
    output logic        m_start_request,
    output logic        m_reset_request,
    output logic [31:0] m_constraint_word,
    output logic        m_constraints_on,
    output logic [31:0] m_commands_seen
);

    // pipeline control
    logic in_valid_reg, mid_valid_reg, out_valid_reg;
    logic out_free, mid_free, in_free;
    logic in_load, mid_load, out_load;

    assign out_free = !out_valid_reg || m_ready;
    assign mid_free = !mid_valid_reg || out_free;
    assign in_free  = !in_valid_reg || mid_free;
    assign s_ready  = in_free;
    assign in_load  = s_valid && in_free;
    assign mid_load = in_valid_reg && mid_free;
    assign out_load = mid_valid_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_load || (in_valid_reg && !mid_free);
            mid_valid_reg <= mid_load || (mid_valid_reg && !out_free);
            out_valid_reg <= out_load || (out_valid_reg && !m_ready);
        end
    end

    // input register
    logic [31:0] in_x_reg, in_y_reg;

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_x_reg <= s_x_word;
            in_y_reg <= s_y_word;
        end
    end

    // decode, state update, multiply
    logic [15:0] wmin_reg, wmax_reg, wmin_next, wmax_next;
    logic        active_reg, active_next;
    logic [31:0] cached_reg;
    logic        cache_valid_reg;
    logic [31:0] count_reg, count_next;
    logic        cmd, start, rst, clear;
    logic [1:0]  cmd_type;
    logic [31:0] eff;
    logic [33:0] prod;
    scd_pkg::mid_t mid_next, mid_reg;

    always_comb begin
        cmd = (in_x_reg[31:30] == scd_pkg::MAGIC_BITS)
           && (in_y_reg[31:30] == scd_pkg::MAGIC_BITS);
        cmd_type    = in_x_reg[29:28];
        start       = 1'b0;
        rst         = 1'b0;
        clear       = 1'b0;
        wmin_next   = wmin_reg;
        wmax_next   = wmax_reg;
        active_next = active_reg;
        if (cmd) begin
            unique case (cmd_type)
                scd_pkg::CMD_START: begin
                    start = 1'b1;
                end
                scd_pkg::CMD_RESET: begin
                    rst = 1'b1;
                end
                scd_pkg::CMD_BOUNDS: begin
                    wmin_next = in_x_reg[15:0];
                    wmax_next = in_y_reg[15:0];
                    if (in_x_reg[15:0] == 16'd0 && in_y_reg[15:0] == 16'd0) begin
                        active_next = 1'b0;
                        clear       = 1'b1;
                    end else begin
                        active_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        count_next = cmd ? count_reg + 32'd1 : count_reg;
        eff        = (cmd && cache_valid_reg) ? cached_reg : in_x_reg;
        prod       = 34'({1'b1, eff[22:0]}) * 34'(scd_pkg::MM_SCALE);

        mid_next.is_cmd = cmd;
        mid_next.start  = start;
        mid_next.rst    = rst;
        mid_next.active = active_next;
        mid_next.clear  = clear;
        mid_next.wmin   = wmin_next;
        mid_next.wmax   = wmax_next;
        mid_next.count  = count_next;
        mid_next.neg    = eff[31];
        mid_next.nan    = (eff[30:23] == 8'hFF) && (eff[22:0] != 23'd0);
        mid_next.ex     = eff[30:23];
        mid_next.prod   = prod;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wmin_reg        <= 16'd0;
            wmax_reg        <= 16'd0;
            active_reg      <= 1'b0;
            cached_reg      <= 32'd0;
            cache_valid_reg <= 1'b0;
            count_reg       <= 32'd0;
        end else if (mid_load) begin
            wmin_reg   <= wmin_next;
            wmax_reg   <= wmax_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            if (!cmd) begin
                cached_reg      <= in_x_reg;
                cache_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_load) begin
            mid_reg <= mid_next;
        end
    end

    // round to 24 bits, scale, saturate, form relative bounds
    logic        hi;
    logic [23:0] keep;
    logic        guard, sticky, round_up;
    logic [24:0] keep_r, shifted;
    logic [8:0]  exs, tsh;
    logic        sat;
    logic [15:0] mag, mm;
    logic [31:0] packed_reg, packed_next;

    always_comb begin
        hi       = mid_reg.prod[33];
        keep     = hi ? mid_reg.prod[33:10] : mid_reg.prod[32:9];
        guard    = hi ? mid_reg.prod[9] : mid_reg.prod[8];
        sticky   = hi ? (|mid_reg.prod[8:0]) : (|mid_reg.prod[7:0]);
        round_up = guard && (sticky || keep[0]);
        keep_r   = {1'b0, keep} + 25'(round_up);
        exs      = {1'b0, mid_reg.ex} + (hi ? 9'd10 : 9'd9);
        sat      = exs > scd_pkg::SAT_LIMIT;
        tsh      = scd_pkg::EXP_OFFSET - exs;
        shifted  = keep_r >> tsh[4:0];
        mag      = (tsh >= scd_pkg::SHIFT_ZERO) ? 16'd0 : shifted[15:0];
        if (mid_reg.nan) begin
            mm = 16'd0;
        end else if (mid_reg.neg) begin
            mm = (sat || mag[15]) ? 16'h8000 : (~mag + 16'd1);
        end else begin
            mm = (sat || mag[15]) ? 16'h7FFF : mag;
        end
        if (mid_reg.active) begin
            packed_next = {mid_reg.wmax - mm, mid_reg.wmin - mm};
        end else if (mid_reg.clear) begin
            packed_next = 32'd0;
        end else begin
            packed_next = packed_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packed_reg <= 32'd0;
        end else if (out_load) begin
            packed_reg <= packed_next;
        end
    end

    // result register
    logic        is_cmd_reg, start_reg, rst_reg, on_reg;
    logic [31:0] cword_reg, seen_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            is_cmd_reg <= mid_reg.is_cmd;
            start_reg  <= mid_reg.start;
            rst_reg    <= mid_reg.rst;
            cword_reg  <= packed_next;
            on_reg     <= mid_reg.active;
            seen_reg   <= mid_reg.count;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_is_command      = is_cmd_reg;
    assign m_start_request   = start_reg;
    assign m_reset_request   = rst_reg;
    assign m_constraint_word = cword_reg;
    assign m_constraints_on  = on_reg;
    assign m_commands_seen   = seen_reg;

    a_flag_needs_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_start_request || m_reset_request) |-> m_is_command)
        else $error("request flag without command");

    a_off_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_constraints_on |-> m_constraint_word == 32'd0)
        else $error("constraint word nonzero while constraints off");

    a_count_moves_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |-> $past(mid_load))
        else $error("command count changed without a request");

endmodule
